/* rtl/c2p_pkg.sv */
// Package for the complex to polar converter: default widths, CORDIC angle
// table, register indexes and mode codes. No dependencies.
`timescale 1ns / 1ps

package c2p_pkg;

    // Default field widths.
    localparam int DATA_WIDTH_DEF  = 32;
    localparam int PHASE_WIDTH_DEF = 16;

    // Register indexes on the configuration port.
    localparam logic REG_MODE    = 1'b0;
    localparam logic REG_MISSING = 1'b1;

    // Mode codes.
    localparam logic MODE_RECT  = 1'b0;
    localparam logic MODE_POLAR = 1'b1;

    // Phase datapath geometry. The larger part is normalized so that its top
    // bit lands at bit NORM_W-1; x and y then grow by less than 2^2.
    localparam int NORM_W       = 60;
    localparam int NORM_STAGES  = 6;
    localparam int XW           = 63;
    localparam int CORDIC_STEPS = 32;
    localparam int ANG_FRAC     = 32;
    localparam int ZW           = 36;

    // Register stages of the phase unit: abs, normalize, pre-rotate, CORDIC, round.
    localparam int PH_LAT = 1 + NORM_STAGES + 1 + CORDIC_STEPS + 1;

    // pi in radians scaled by 2^32, rounded.
    localparam logic signed [ZW-1:0] PI_Q32 = 36'sh3243F6A89;

    // atan(2^-i) scaled by 2^32, rounded.
    localparam logic signed [ZW-1:0] ATAN_TAB [CORDIC_STEPS] = '{
        36'sd3373259426, 36'sd1991351318, 36'sd1052175346, 36'sd534100635,
        36'sd268086748,  36'sd134174063,  36'sd67103403,   36'sd33553749,
        36'sd16777131,   36'sd8388597,    36'sd4194303,    36'sd2097152,
        36'sd1048576,    36'sd524288,     36'sd262144,     36'sd131072,
        36'sd65536,      36'sd32768,      36'sd16384,      36'sd8192,
        36'sd4096,       36'sd2048,       36'sd1024,       36'sd512,
        36'sd256,        36'sd128,        36'sd64,         36'sd32,
        36'sd16,         36'sd8,          36'sd4,          36'sd2
    };

endpackage

/* rtl/complex_to_polar_converter.sv */
// Complex to polar converter, top level: config registers, bypass line,
// magnitude and phase pipelines, output register. Depends on c2p_pkg, c2p_regs,
// c2p_mag and c2p_phase. Depth is set by the 32-stage CORDIC or the one-bit-per-stage
// square root, whichever is longer. Throughput is one beat per cycle while o_stall is
// low. Reset (synchronous, active low) clears all valid bits, selects rectangular
// mode and sets the missing code to the most negative value.
`timescale 1ns / 1ps

module complex_to_polar_converter #(
    parameter  int DATA_WIDTH  = c2p_pkg::DATA_WIDTH_DEF,
    parameter  int PHASE_WIDTH = c2p_pkg::PHASE_WIDTH_DEF,
    localparam int APB_DW      = (DATA_WIDTH > 32) ? 64 : 32,
    localparam int PAW         = (DATA_WIDTH > 32) ? 4 : 3
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // Input channel.
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic signed [DATA_WIDTH-1:0] i_real_part,
    input  logic signed [DATA_WIDTH-1:0] i_imag_part,
    // Output channel.
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic signed [DATA_WIDTH:0]   o_first_value,
    output logic signed [DATA_WIDTH-1:0] o_second_value,
    // Configuration port.
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [PAW-1:0]               paddr,
    input  logic [APB_DW-1:0]            pwdata,
    output logic [APB_DW-1:0]            prdata,
    output logic                         pready
);

    localparam int DW  = DATA_WIDTH;
    // Both units are padded to the same depth so their results line up.
    localparam int LAT = (c2p_pkg::PH_LAT > DW + 5) ? c2p_pkg::PH_LAT : DW + 5;

    logic                 w_mode;
    logic [DW-1:0]        w_missing;
    logic                 w_adv, w_out_load, w_polar, w_miss;
    logic signed [DW-1:0] n_byp_re, n_byp_im;
    logic                 n_calc;
    logic [DW:0]          w_mag;
    logic signed [DW-1:0] w_phase;

    logic                 r_vld    [LAT];
    logic                 r_calc   [LAT];
    logic signed [DW-1:0] r_byp_re [LAT];
    logic signed [DW-1:0] r_byp_im [LAT];

    logic                 r_out_valid;
    logic signed [DW:0]   r_first;
    logic signed [DW-1:0] r_second;

    c2p_regs #(
        .DATA_WIDTH (DATA_WIDTH),
        .APB_DW     (APB_DW),
        .PAW        (PAW)
    ) u_regs (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_psel         (psel),
        .i_penable      (penable),
        .i_pwrite       (pwrite),
        .i_paddr        (paddr),
        .i_pwdata       (pwdata),
        .o_prdata       (prdata),
        .o_mode         (w_mode),
        .o_missing_code (w_missing)
    );

    assign pready = 1'b1;

    // The whole pipeline moves one step unless a result is waiting at the
    // output and another one is already in the last stage behind it. While the
    // last stage is empty, new beats keep entering even though the output is held.
    assign w_adv      = !(r_out_valid && i_stall && r_vld[LAT-1]);
    assign w_out_load = !r_out_valid || !i_stall;
    assign o_stall    = !w_adv;

    // Mode and the missing-value check are settled on entry; both ride as one bit.
    // Configuration must only change while the block is empty; nothing enforces it.
    // A missing sample in polar mode takes the bypass path carrying the code.
    assign w_polar  = (w_mode == c2p_pkg::MODE_POLAR);
    assign w_miss   = (i_real_part == w_missing) || (i_imag_part == w_missing);
    assign n_calc   = w_polar && !w_miss;
    assign n_byp_re = (w_polar && w_miss) ? w_missing : i_real_part;
    assign n_byp_im = (w_polar && w_miss) ? w_missing : i_imag_part;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LAT; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (w_adv) begin
            r_vld[0] <= i_valid;
            for (int k = 1; k < LAT; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_calc[0]   <= n_calc;
            r_byp_re[0] <= n_byp_re;
            r_byp_im[0] <= n_byp_im;
            for (int k = 1; k < LAT; k++) begin
                r_calc[k]   <= r_calc[k-1];
                r_byp_re[k] <= r_byp_re[k-1];
                r_byp_im[k] <= r_byp_im[k-1];
            end
        end
    end

    c2p_mag #(
        .DATA_WIDTH (DATA_WIDTH),
        .LAT        (LAT)
    ) u_mag (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_re  (i_real_part),
        .i_im  (i_imag_part),
        .o_mag (w_mag)
    );

    c2p_phase #(
        .DATA_WIDTH  (DATA_WIDTH),
        .PHASE_WIDTH (PHASE_WIDTH),
        .LAT         (LAT)
    ) u_phase (
        .i_clk   (i_clk),
        .i_en    (w_adv),
        .i_re    (i_real_part),
        .i_im    (i_imag_part),
        .o_phase (w_phase)
    );

    // Output register. The pass-through real part is sign extended by one bit;
    // the magnitude is unsigned and already fills all DW+1 bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= r_vld[LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_first  <= r_calc[LAT-1] ? $signed(w_mag)
                                      : {r_byp_re[LAT-1][DW-1], r_byp_re[LAT-1]};
            r_second <= r_calc[LAT-1] ? w_phase : r_byp_im[LAT-1];
        end
    end

    assign o_valid        = r_out_valid;
    assign o_first_value  = r_first;
    assign o_second_value = r_second;

endmodule

/* rtl/c2p_regs.sv */
// Configuration registers of the complex to polar converter behind an
// APB-style port. Depends on c2p_pkg.
`timescale 1ns / 1ps

module c2p_regs #(
    parameter int DATA_WIDTH = c2p_pkg::DATA_WIDTH_DEF,
    parameter int APB_DW     = 32,
    parameter int PAW        = 3
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_psel,
    input  logic                  i_penable,
    input  logic                  i_pwrite,
    input  logic [PAW-1:0]        i_paddr,
    input  logic [APB_DW-1:0]     i_pwdata,
    output logic [APB_DW-1:0]     o_prdata,
    output logic                  o_mode,
    output logic [DATA_WIDTH-1:0] o_missing_code
);

    logic                  r_mode;
    logic [DATA_WIDTH-1:0] r_missing;
    logic                  w_idx;
    logic                  w_wr;

    // Only the top address bit selects a register; the rest is byte offset.
    assign w_idx = i_paddr[PAW-1];
    assign w_wr  = i_psel && i_penable && i_pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= c2p_pkg::MODE_RECT;
            r_missing <= {1'b1, {(DATA_WIDTH-1){1'b0}}};
        end else if (w_wr) begin
            unique case (w_idx)
                c2p_pkg::REG_MODE:    r_mode    <= i_pwdata[0];
                c2p_pkg::REG_MISSING: r_missing <= i_pwdata[DATA_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            c2p_pkg::REG_MODE:    o_prdata = APB_DW'(r_mode);
            c2p_pkg::REG_MISSING: o_prdata = APB_DW'(r_missing);
            default:              o_prdata = '0;
        endcase
    end

    assign o_mode         = r_mode;
    assign o_missing_code = r_missing;

endmodule

/* rtl/c2p_mag.sv */
// Magnitude pipeline: split squares, sum, one root bit per stage, rounding.
// Depends on c2p_pkg.
`timescale 1ns / 1ps

module c2p_mag #(
    parameter int DATA_WIDTH = c2p_pkg::DATA_WIDTH_DEF,
    parameter int LAT        = c2p_pkg::PH_LAT
) (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic signed [DATA_WIDTH-1:0] i_re,
    input  logic signed [DATA_WIDTH-1:0] i_im,
    output logic        [DATA_WIDTH:0]   o_mag
);

    localparam int DW  = DATA_WIDTH;
    localparam int HW  = (DW + 1) / 2;
    localparam int UW  = DW - HW;
    localparam int SW  = 2 * DW;
    localparam int MW  = DW + 1;
    localparam int OWN = DW + 5;
    localparam int PAD = LAT - OWN;

    logic [DW-1:0]   n_ax, n_ay, r_ax, r_ay;
    logic [2*UW-1:0] r_hh_x, r_hh_y;
    logic [DW-1:0]   r_hl_x, r_hl_y;
    logic [2*HW-1:0] r_ll_x, r_ll_y;
    logic [SW-1:0]   r_sq_x, r_sq_y, r_sum;
    logic [SW-1:0]   r_rem  [DW];
    logic [DW-1:0]   r_root [DW];
    logic [MW-1:0]   n_mag, r_mag;
    logic            w_up;

    assign n_ax = i_re[DW-1] ? (~i_re + 1'b1) : i_re;
    assign n_ay = i_im[DW-1] ? (~i_im + 1'b1) : i_im;

    // Each square is built from half-width partial products.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ax   <= n_ax;
            r_ay   <= n_ay;
            r_hh_x <= r_ax[DW-1:HW] * r_ax[DW-1:HW];
            r_hl_x <= r_ax[DW-1:HW] * r_ax[HW-1:0];
            r_ll_x <= r_ax[HW-1:0] * r_ax[HW-1:0];
            r_hh_y <= r_ay[DW-1:HW] * r_ay[DW-1:HW];
            r_hl_y <= r_ay[DW-1:HW] * r_ay[HW-1:0];
            r_ll_y <= r_ay[HW-1:0] * r_ay[HW-1:0];
            r_sq_x <= {r_hh_x, r_ll_x} + (SW'(r_hl_x) << (HW + 1));
            r_sq_y <= {r_hh_y, r_ll_y} + (SW'(r_hl_y) << (HW + 1));
            r_sum  <= r_sq_x + r_sq_y;
        end
    end

    // Restoring square root; the remainder is always sum minus root squared.
    for (genvar k = 0; k < DW; k++) begin : g_root
        localparam int B = DW - 1 - k;
        logic [SW-1:0] rem_in, trial;
        logic [DW-1:0] root_in;
        logic          ge;

        if (k == 0) begin : g_first
            assign rem_in  = r_sum;
            assign root_in = '0;
        end else begin : g_next
            assign rem_in  = r_rem[k-1];
            assign root_in = r_root[k-1];
        end

        assign trial = (SW'(root_in) << (B + 1)) | (SW'(1) << (2 * B));
        assign ge    = (rem_in >= trial);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= ge ? (rem_in - trial) : rem_in;
                r_root[k] <= ge ? (root_in | (DW'(1) << B)) : root_in;
            end
        end
    end

    // Round to nearest: go up when the remainder exceeds the root.
    assign w_up  = (r_rem[DW-1] > SW'(r_root[DW-1]));
    assign n_mag = MW'(r_root[DW-1]) + MW'(w_up);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mag <= n_mag;
        end
    end

    if (PAD > 0) begin : g_pad
        logic [MW-1:0] r_pad [PAD];
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_pad[0] <= r_mag;
                for (int p = 1; p < PAD; p++) begin
                    r_pad[p] <= r_pad[p-1];
                end
            end
        end
        assign o_mag = r_pad[PAD-1];
    end else begin : g_nopad
        assign o_mag = r_mag;
    end

endmodule

/* rtl/c2p_phase.sv */
// Phase pipeline: absolute values, normalizing shifts, quadrant fold, an
// unrolled 32-stage vectoring CORDIC and rounding. Depends on c2p_pkg.
`timescale 1ns / 1ps

module c2p_phase #(
    parameter int DATA_WIDTH  = c2p_pkg::DATA_WIDTH_DEF,
    parameter int PHASE_WIDTH = c2p_pkg::PHASE_WIDTH_DEF,
    parameter int LAT         = c2p_pkg::PH_LAT
) (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic signed [DATA_WIDTH-1:0] i_re,
    input  logic signed [DATA_WIDTH-1:0] i_im,
    output logic signed [DATA_WIDTH-1:0] o_phase
);

    localparam int DW  = DATA_WIDTH;
    localparam int NW  = c2p_pkg::NORM_W;
    localparam int NS  = c2p_pkg::NORM_STAGES;
    localparam int XW  = c2p_pkg::XW;
    localparam int ZW  = c2p_pkg::ZW;
    localparam int CS  = c2p_pkg::CORDIC_STEPS;
    localparam int SH  = c2p_pkg::ANG_FRAC + 3 - PHASE_WIDTH;
    localparam int PAD = LAT - c2p_pkg::PH_LAT;
    localparam logic signed [ZW-1:0] RND = ZW'(64'd1 << (SH - 1));

    logic [DW-1:0]          n_ux, n_uy, r_ux, r_uy;
    logic                   r_sx, r_sy;
    logic [NW-1:0]          r_nx  [NS];
    logic [NW-1:0]          r_ny  [NS];
    logic                   r_nsx [NS];
    logic                   r_nsy [NS];
    logic signed [XW-1:0]   r_cx  [CS+1];
    logic signed [XW-1:0]   r_cy  [CS+1];
    logic signed [ZW-1:0]   r_cz  [CS+1];
    logic                   r_czero [CS+1];
    logic signed [XW-1:0]   n_x0, n_y0, w_ys;
    logic signed [ZW-1:0]   n_z0, w_zs, w_zr;
    logic signed [DW-1:0]   r_phase;

    assign n_ux = i_re[DW-1] ? (~i_re + 1'b1) : i_re;
    assign n_uy = i_im[DW-1] ? (~i_im + 1'b1) : i_im;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ux <= n_ux;
            r_uy <= n_uy;
            r_sx <= i_re[DW-1];
            r_sy <= i_im[DW-1];
        end
    end

    // Binary search for the common left shift, one power of two per stage.
    for (genvar j = 0; j < NS; j++) begin : g_norm
        localparam int K = 1 << (NS - 1 - j);
        logic [NW-1:0] x_in, y_in;
        logic          sx_in, sy_in, hit;

        if (j == 0) begin : g_first
            assign x_in  = NW'(r_ux);
            assign y_in  = NW'(r_uy);
            assign sx_in = r_sx;
            assign sy_in = r_sy;
        end else begin : g_next
            assign x_in  = r_nx[j-1];
            assign y_in  = r_ny[j-1];
            assign sx_in = r_nsx[j-1];
            assign sy_in = r_nsy[j-1];
        end

        assign hit = ~|(x_in[NW-1 -: K] | y_in[NW-1 -: K]);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_nx[j]  <= hit ? (x_in << K) : x_in;
                r_ny[j]  <= hit ? (y_in << K) : y_in;
                r_nsx[j] <= sx_in;
                r_nsy[j] <= sy_in;
            end
        end
    end

    // Fold into the right half plane; a negative real part starts at +pi or -pi.
    assign w_ys = $signed(XW'(r_ny[NS-1]));
    assign n_x0 = $signed(XW'(r_nx[NS-1]));
    assign n_y0 = (r_nsx[NS-1] ^ r_nsy[NS-1]) ? -w_ys : w_ys;
    assign n_z0 = r_nsx[NS-1] ? (r_nsy[NS-1] ? -c2p_pkg::PI_Q32 : c2p_pkg::PI_Q32) : '0;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cx[0]    <= n_x0;
            r_cy[0]    <= n_y0;
            r_cz[0]    <= n_z0;
            r_czero[0] <= ~(r_nx[NS-1][NW-1] | r_ny[NS-1][NW-1]);
        end
    end

    for (genvar i = 0; i < CS; i++) begin : g_cordic
        logic signed [XW-1:0] dx, dy;
        logic                 neg;

        assign dx  = r_cy[i] >>> i;
        assign dy  = r_cx[i] >>> i;
        assign neg = r_cy[i][XW-1];

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_cx[i+1]    <= neg ? (r_cx[i] - dx) : (r_cx[i] + dx);
                r_cy[i+1]    <= neg ? (r_cy[i] + dy) : (r_cy[i] - dy);
                r_cz[i+1]    <= neg ? (r_cz[i] - c2p_pkg::ATAN_TAB[i])
                                    : (r_cz[i] + c2p_pkg::ATAN_TAB[i]);
                r_czero[i+1] <= r_czero[i];
            end
        end
    end

    // Round half up to the phase fraction; a zero sample has phase zero.
    assign w_zs = r_cz[CS] + RND;
    assign w_zr = w_zs >>> SH;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_phase <= r_czero[CS] ? '0 : DW'(w_zr);
        end
    end

    if (PAD > 0) begin : g_pad
        logic signed [DW-1:0] r_pad [PAD];
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_pad[0] <= r_phase;
                for (int p = 1; p < PAD; p++) begin
                    r_pad[p] <= r_pad[p-1];
                end
            end
        end
        assign o_phase = r_pad[PAD-1];
    end else begin : g_nopad
        assign o_phase = r_phase;
    end

endmodule

/* rtl/c2p_checker.sv */
// Port-level checker for the complex to polar converter, bound to the top
// level. Depends on complex_to_polar_converter.
`timescale 1ns / 1ps

module c2p_port_checks #(
    parameter int DATA_WIDTH = c2p_pkg::DATA_WIDTH_DEF
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         o_stall,
    input logic                         o_valid,
    input logic                         i_stall,
    input logic signed [DATA_WIDTH:0]   o_first_value,
    input logic signed [DATA_WIDTH-1:0] o_second_value
);

    // No result shows right after reset.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // Backpressure only comes from a result held at the output.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without a held result");

    // A held result does not change.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_first_value)
                                  && $stable(o_second_value)))
        else $error("held result changed");

    // The first field is either a sign-extended sample or an unsigned
    // magnitude, so it never lies below the most negative sample value.
    a_first_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_first_value[DATA_WIDTH] && !o_first_value[DATA_WIDTH-1]))
        else $error("first field out of range");

endmodule

bind complex_to_polar_converter c2p_port_checks #(
    .DATA_WIDTH (DATA_WIDTH)
) u_c2p_port_checks (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_stall        (o_stall),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_first_value  (o_first_value),
    .o_second_value (o_second_value)
);
